// ===== hdl/srtf_pkg.sv =====
// Shared types and constants for the shortest-remaining-time scheduler.
// Holds the item structs, the job table entry and the sequencer state type.
// No dependencies.
package srtf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int TIME_W   = 16;
  localparam int PC_W     = 5;
  localparam int SUM_W    = 32;

  localparam logic [TIME_W-1:0] TIME_MAX     = '1;
  localparam logic [PC_W-1:0]   PC_RESET     = PC_W'(16);
  localparam logic [PC_W-1:0]   DONE_MAX     = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [3:0]        slot;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic              ran;
    logic [3:0]        running_slot;
    logic              completed;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              all_done;
    logic [SUM_W-1:0]  total_wait;
    logic [SUM_W-1:0]  total_turnaround;
  } out_item_t;

  // One job slot as kept in the table memory.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  // Registered read response; present is low for a slot never loaded.
  typedef struct packed {
    logic   present;
    entry_t entry;
  } rd_resp_t;

  // Current choice of job during a scan.
  typedef struct packed {
    logic              have;
    logic [TIME_W-1:0] best;
    logic [IDX_W-1:0]  slot;
  } pick_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/srtf_table.sv =====
// Job table: one synchronous memory of slot entries with a registered read.
// Per-slot valid bits mark an unloaded slot as not present in the read response.
// Depends on srtf_pkg.
module srtf_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [srtf_pkg::IDX_W-1:0]    rd_addr,
  input  logic                          wr_en,
  input  logic [srtf_pkg::IDX_W-1:0]    wr_addr,
  input  srtf_pkg::entry_t              wr_entry,
  output srtf_pkg::rd_resp_t            rd_resp
);

  srtf_pkg::entry_t                 mem [srtf_pkg::MAX_JOBS];
  logic [srtf_pkg::MAX_JOBS-1:0]    loaded;
  srtf_pkg::entry_t                 rd_entry;
  logic                             rd_present;

  assign rd_resp = {rd_present, rd_entry};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= '0;
      rd_present <= 1'b0;
    end else begin
      if (wr_en) begin
        loaded[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_present <= loaded[rd_addr];
      end
    end
  end

endmodule

// ===== hdl/srtf_pick.sv =====
// Running selection of the job with the least remaining time.
// Compares one table read per cycle, while cmp_en is high, against the current choice.
// Depends on srtf_pkg.
module srtf_pick (
  input  logic                              clk,
  input  logic                              init,
  input  srtf_pkg::pick_t                   init_pick,
  input  logic                              cmp_en,
  input  logic [srtf_pkg::IDX_W-1:0]        cmp_slot,
  input  srtf_pkg::rd_resp_t                rd_resp,
  input  logic [srtf_pkg::TIME_W-1:0]       now,
  output srtf_pkg::pick_t                   sel,
  output srtf_pkg::pick_t                   sel_next
);

  logic [srtf_pkg::TIME_W-1:0] rem;
  logic                        better;

  always_comb begin
    rem      = rd_resp.present ? rd_resp.entry.remaining : '0;
    // Only a strictly shorter job displaces the current one, so ties keep
    // the held job or the lower slot.
    better   = cmp_en && (rem != '0) && (rd_resp.entry.arrival <= now) &&
               (!sel.have || (rem < sel.best));
    sel_next = sel;
    if (better) begin
      sel_next.have = 1'b1;
      sel_next.best = rem;
      sel_next.slot = cmp_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      sel <= init_pick;
    end else if (cmp_en) begin
      sel <= sel_next;
    end
  end

endmodule

// ===== hdl/shortest_remaining_time_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Holds the sequencer, run state and output register; uses srtf_table,
// srtf_pick and srtf_pkg.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -----------------------------------
//   in        in_valid / in_ready    in_data  (srtf_pkg::in_item_t)
//   out       out_valid / out_ready  out_data (srtf_pkg::out_item_t)
//   cfg       cfg_valid / cfg_ready  cfg_data (process_count, 5 bits)
//
// A tick scans the first limit slots, where limit is the smaller of
// process_count and the table depth; the scan reads one table entry per
// cycle through the single read port, then the chosen job's entry is
// fetched and updated and its result goes to the output register. A load,
// or a tick after the run has finished, goes straight to the finish step.
// No new input is taken until the sequencer is back in its idle step.
// Reset is synchronous; it clears the run state, the table's valid bits and
// sets process_count to 16. The next input is taken while a result waits in
// the output register; a stalled result holds the sequencer in its last step.
module shortest_remaining_time_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  srtf_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output srtf_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srtf_pkg::PC_W-1:0]     cfg_data
);

  localparam int IW = srtf_pkg::IDX_W;
  localparam int TW = srtf_pkg::TIME_W;
  localparam int SW = srtf_pkg::SUM_W;

  srtf_pkg::state_t state, state_next;

  // Run state.
  logic [srtf_pkg::PC_W-1:0] process_count;
  logic [TW-1:0]             current_time;
  logic                      held_valid;
  logic [IW-1:0]             held_slot;
  logic [TW-1:0]             held_remaining;
  logic [srtf_pkg::PC_W-1:0] done_count;
  logic [SW-1:0]             wait_sum;
  logic [SW-1:0]             turnaround_sum;

  // Scan bookkeeping.
  logic [IW-1:0]             scan_idx;
  logic [IW-1:0]             scan_last;
  logic                      cmp_en;
  logic [IW-1:0]             cmp_slot;

  // Result of the current item, collected before the output register.
  logic                      res_ran;
  logic [IW-1:0]             res_slot;
  logic                      res_comp;
  logic [TW-1:0]             res_fin;
  logic [TW-1:0]             res_wait;
  logic [TW-1:0]             res_turn;

  // Sequencer controls.
  logic                      accept;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  srtf_pkg::entry_t          wr_entry;
  logic                      out_free;

  srtf_pkg::rd_resp_t        rd_resp;
  srtf_pkg::pick_t           init_pick;
  srtf_pkg::pick_t           sel;
  srtf_pkg::pick_t           sel_next;

  // Datapath helpers.
  logic                      load_ok;
  logic                      run_over;
  logic [srtf_pkg::CNT_W-1:0] limit;
  logic [TW-1:0]             pick_rem;
  logic                      pick_run;
  logic [TW-1:0]             time_inc;
  logic [TW:0]               need;
  logic [TW:0]               wait_full;
  logic [TW:0]               turn_full;
  logic [SW:0]               wait_add;
  logic [SW:0]               turn_add;
  logic [SW-1:0]             wait_sum_next;
  logic [SW-1:0]             turn_sum_next;

  assign in_ready  = (state == srtf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  srtf_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_resp  (rd_resp)
  );

  srtf_pick u_pick (
    .clk       (clk),
    .init      (accept),
    .init_pick (init_pick),
    .cmp_en    (cmp_en),
    .cmp_slot  (cmp_slot),
    .rd_resp   (rd_resp),
    .now       (current_time),
    .sel       (sel),
    .sel_next  (sel_next)
  );

  always_comb begin
    load_ok  = 32'(in_data.slot) < 32'(srtf_pkg::MAX_JOBS);
    run_over = 32'(done_count) >= 32'(process_count);
    if (32'(process_count) < 32'(srtf_pkg::MAX_JOBS)) begin
      limit = srtf_pkg::CNT_W'(process_count);
    end else begin
      limit = srtf_pkg::CNT_W'(srtf_pkg::MAX_JOBS);
    end

    // The scan starts from the held job, which keeps the processor on ties.
    init_pick.have = held_valid;
    init_pick.best = held_remaining;
    init_pick.slot = held_valid ? held_slot : '0;

    // In the update step the read response is the chosen job's entry.
    pick_rem  = rd_resp.present ? rd_resp.entry.remaining : '0;
    pick_run  = sel.have && (pick_rem != '0);
    time_inc  = (current_time == srtf_pkg::TIME_MAX) ? current_time
                                                     : current_time + 1'b1;
    need      = {1'b0, rd_resp.entry.arrival} + {1'b0, rd_resp.entry.burst};
    wait_full = ({1'b0, time_inc} >= need) ? {1'b0, time_inc} - need : '0;
    turn_full = (time_inc >= rd_resp.entry.arrival) ?
                {1'b0, time_inc - rd_resp.entry.arrival} : '0;

    // Saturating totals, applied when the result is registered.
    wait_add      = {1'b0, wait_sum} + (SW + 1)'(res_wait);
    turn_add      = {1'b0, turnaround_sum} + (SW + 1)'(res_turn);
    wait_sum_next = wait_add[SW] ? '1 : wait_add[SW-1:0];
    turn_sum_next = turn_add[SW] ? '1 : turn_add[SW-1:0];
    if (!res_comp) begin
      wait_sum_next = wait_sum;
      turn_sum_next = turnaround_sum;
    end
  end

  // Sequencer: next state and memory port controls.
  always_comb begin
    state_next        = state;
    rd_en             = 1'b0;
    rd_addr           = scan_idx;
    wr_en             = 1'b0;
    wr_addr           = IW'(in_data.slot);
    wr_entry.arrival  = in_data.arrival_time;
    wr_entry.burst    = in_data.burst_length;
    wr_entry.remaining = in_data.burst_length;
    case (state)
      srtf_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == srtf_pkg::OP_LOAD) begin
            wr_en      = load_ok;
            state_next = srtf_pkg::ST_FINISH;
          end else if (run_over) begin
            state_next = srtf_pkg::ST_FINISH;
          end else begin
            state_next = srtf_pkg::ST_SCAN;
          end
        end
      end
      srtf_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx == scan_last) begin
          state_next = srtf_pkg::ST_FETCH;
        end
      end
      srtf_pkg::ST_FETCH: begin
        // The last scanned entry is folded in on the way to the address.
        rd_en      = 1'b1;
        rd_addr    = sel_next.slot;
        state_next = srtf_pkg::ST_UPDATE;
      end
      srtf_pkg::ST_UPDATE: begin
        wr_en              = pick_run;
        wr_addr            = sel.slot;
        wr_entry.arrival   = rd_resp.entry.arrival;
        wr_entry.burst     = rd_resp.entry.burst;
        wr_entry.remaining = pick_rem - 1'b1;
        state_next         = srtf_pkg::ST_FINISH;
      end
      srtf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = srtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= srtf_pkg::PC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      process_count <= cfg_data;
    end
  end

  // Scan counter and compare pipeline; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx  <= '0;
      scan_last <= IW'(limit - 1'b1);
    end else if (state == srtf_pkg::ST_SCAN && scan_idx != scan_last) begin
      scan_idx <= scan_idx + 1'b1;
    end
    cmp_slot <= scan_idx;
  end

  // Run state and the per-item result.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en         <= 1'b0;
      current_time   <= '0;
      held_valid     <= 1'b0;
      held_slot      <= '0;
      held_remaining <= '0;
      done_count     <= '0;
      wait_sum       <= '0;
      turnaround_sum <= '0;
      res_ran        <= 1'b0;
      res_comp       <= 1'b0;
    end else begin
      cmp_en <= (state == srtf_pkg::ST_SCAN);
      if (accept) begin
        res_ran  <= 1'b0;
        res_comp <= 1'b0;
        res_slot <= '0;
        res_fin  <= '0;
        res_wait <= '0;
        res_turn <= '0;
        if (in_data.operation == srtf_pkg::OP_LOAD && load_ok) begin
          current_time   <= '0;
          done_count     <= '0;
          wait_sum       <= '0;
          turnaround_sum <= '0;
          held_valid     <= 1'b0;
          held_slot      <= '0;
          held_remaining <= '0;
        end
      end
      if (state == srtf_pkg::ST_UPDATE) begin
        current_time <= time_inc;
        if (!pick_run) begin
          held_valid <= 1'b0;
        end else begin
          res_ran  <= 1'b1;
          res_slot <= sel.slot;
          if (pick_rem == TW'(1)) begin
            res_comp       <= 1'b1;
            res_fin        <= time_inc;
            res_wait       <= wait_full[TW-1:0];
            res_turn       <= turn_full[TW-1:0];
            held_valid     <= 1'b0;
            held_slot      <= '0;
            held_remaining <= '0;
            if (done_count != srtf_pkg::DONE_MAX) begin
              done_count <= done_count + 1'b1;
            end
          end else begin
            held_valid     <= 1'b1;
            held_slot      <= sel.slot;
            held_remaining <= pick_rem - 1'b1;
          end
        end
      end
      if (state == srtf_pkg::ST_FINISH && out_free) begin
        wait_sum       <= wait_sum_next;
        turnaround_sum <= turn_sum_next;
      end
    end
  end

  // Output register: a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == srtf_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srtf_pkg::ST_FINISH && out_free) begin
      out_data.ran              <= res_ran;
      out_data.running_slot     <= 4'(res_slot);
      out_data.completed        <= res_comp;
      out_data.end_time         <= res_fin;
      out_data.wait_time        <= res_wait;
      out_data.turnaround_time  <= res_turn;
      out_data.all_done         <= run_over;
      out_data.total_wait       <= wait_sum_next;
      out_data.total_turnaround <= turn_sum_next;
    end
  end

  // An accepted item always leaves the sequencer busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sequencer took a second item without processing the first");

  // The table is written only by a load or by the update step.
  a_write_steps: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == srtf_pkg::ST_IDLE || state == srtf_pkg::ST_UPDATE))
    else $error("table written outside a load or update step");

  // A completion is always a tick that ran a job, and waiting never exceeds
  // turnaround.
  a_completion_sane: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.completed) |->
      (out_data.ran && out_data.turnaround_time >= out_data.wait_time))
    else $error("completion result inconsistent");

  // A result is produced only after the finish step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == srtf_pkg::ST_FINISH)
    else $error("result appeared without a finish step");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for shortest_remaining_time_scheduler.
// A scoreboard class predicts every load and tick result; plain tasks drive the
// input and process-count channels. Depends on srtf_pkg and the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Cycles to watch for stray results after the last expected one arrived.
  localparam int SETTLE_CYCLES = 40;
  // Input items per random phase; with the overrun of each phase's last batch
  // and the directed part, eight phases give about 1750 items.
  localparam int PHASE_ITEMS   = 180;
  // Longest tick sequence of one random batch.
  localparam int BATCH_TICKS   = 120;

  // Tracks the scheduler's run state, works out the result of each accepted
  // input item and compares the block's results against them in order.
  class schedule_board;
    logic [srtf_pkg::TIME_W-1:0] job_arrival [srtf_pkg::MAX_JOBS] = '{default: '0};
    logic [srtf_pkg::TIME_W-1:0] job_burst   [srtf_pkg::MAX_JOBS] = '{default: '0};
    logic [srtf_pkg::TIME_W-1:0] job_left    [srtf_pkg::MAX_JOBS] = '{default: '0};
    logic [srtf_pkg::TIME_W-1:0] clock_now   = '0;
    logic [srtf_pkg::IDX_W-1:0]  owner_slot  = '0;
    logic [srtf_pkg::TIME_W-1:0] owner_left  = '0;
    logic                        owner_live  = 1'b0;
    logic [srtf_pkg::PC_W-1:0]   jobs_done   = '0;
    logic [srtf_pkg::SUM_W-1:0]  wait_total  = '0;
    logic [srtf_pkg::SUM_W-1:0]  turn_total  = '0;
    logic [srtf_pkg::PC_W-1:0]   job_count   = srtf_pkg::PC_RESET;
    srtf_pkg::out_item_t         pending_reports [$];
    int                          errors      = 0;

    function logic [srtf_pkg::SUM_W-1:0] sat_add(logic [srtf_pkg::SUM_W-1:0] acc,
                                                 logic [srtf_pkg::TIME_W-1:0] add);
      logic [srtf_pkg::SUM_W:0] sum;
      sum = {1'b0, acc} + add;
      return sum[srtf_pkg::SUM_W] ? '1 : sum[srtf_pkg::SUM_W-1:0];
    endfunction

    function bit finished();
      return jobs_done >= job_count;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void accept_request(srtf_pkg::in_item_t req);
      srtf_pkg::out_item_t         rep;
      int                          span;
      logic                        found;
      logic [srtf_pkg::TIME_W-1:0] best;
      logic [srtf_pkg::IDX_W-1:0]  pick;
      logic [srtf_pkg::TIME_W-1:0] fin;
      logic [srtf_pkg::TIME_W:0]   need;
      logic [srtf_pkg::TIME_W-1:0] waited;
      logic [srtf_pkg::TIME_W-1:0] turned;
      rep = '0;
      if (req.operation == srtf_pkg::OP_LOAD) begin
        // A load writes one slot and restarts the whole run.
        job_arrival[req.slot] = req.arrival_time;
        job_burst[req.slot]   = req.burst_length;
        job_left[req.slot]    = req.burst_length;
        clock_now  = '0;
        jobs_done  = '0;
        wait_total = '0;
        turn_total = '0;
        owner_live = 1'b0;
        owner_slot = '0;
        owner_left = '0;
      end else if (jobs_done < job_count) begin
        span  = (job_count < srtf_pkg::MAX_JOBS) ? int'(job_count) : srtf_pkg::MAX_JOBS;
        found = owner_live;
        best  = owner_left;
        pick  = owner_live ? owner_slot : '0;
        // The held job keeps the processor unless a ready job needs strictly
        // less; the ascending scan makes the lowest slot win a tie.
        for (int j = 0; j < span; j++) begin
          if (job_left[j] != 0 && job_arrival[j] <= clock_now &&
              (!found || job_left[j] < best)) begin
            best  = job_left[j];
            pick  = srtf_pkg::IDX_W'(j);
            found = 1'b1;
          end
        end
        if (found && job_left[pick] == 0) found = 1'b0;
        if (!found) begin
          owner_live = 1'b0;
          if (clock_now != srtf_pkg::TIME_MAX) clock_now = clock_now + 1'b1;
        end else begin
          fin = (clock_now != srtf_pkg::TIME_MAX) ? clock_now + 1'b1 : clock_now;
          job_left[pick]   = job_left[pick] - 1'b1;
          rep.ran          = 1'b1;
          rep.running_slot = pick;
          if (job_left[pick] == 0) begin
            need   = {1'b0, job_arrival[pick]} + job_burst[pick];
            waited = ({1'b0, fin} >= need) ?
                     srtf_pkg::TIME_W'({1'b0, fin} - need) : '0;
            turned = (fin >= job_arrival[pick]) ? fin - job_arrival[pick] : '0;
            rep.completed       = 1'b1;
            rep.end_time        = fin;
            rep.wait_time       = waited;
            rep.turnaround_time = turned;
            wait_total = sat_add(wait_total, waited);
            turn_total = sat_add(turn_total, turned);
            if (jobs_done != srtf_pkg::DONE_MAX) jobs_done = jobs_done + 1'b1;
            owner_live = 1'b0;
            owner_slot = '0;
            owner_left = '0;
          end else begin
            owner_live = 1'b1;
            owner_slot = pick;
            owner_left = job_left[pick];
          end
          clock_now = fin;
        end
      end
      rep.all_done         = jobs_done >= job_count;
      rep.total_wait       = wait_total;
      rep.total_turnaround = turn_total;
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string label, logic [srtf_pkg::SUM_W-1:0] want,
                                logic [srtf_pkg::SUM_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    function void check_report(srtf_pkg::out_item_t got);
      srtf_pkg::out_item_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("ran", want.ran, got.ran);
      compare_field("running_slot", want.running_slot, got.running_slot);
      compare_field("completed", want.completed, got.completed);
      compare_field("end_time", want.end_time, got.end_time);
      compare_field("wait_time", want.wait_time, got.wait_time);
      compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
      compare_field("all_done", want.all_done, got.all_done);
      compare_field("total_wait", want.total_wait, got.total_wait);
      compare_field("total_turnaround", want.total_turnaround, got.total_turnaround);
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  srtf_pkg::in_item_t        in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  srtf_pkg::out_item_t       out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [srtf_pkg::PC_W-1:0] cfg_data  = srtf_pkg::PC_RESET;

  schedule_board board = new;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int phase_items    = 0;
  int stall_cycles   = 0;

  // Idling plan: none, sender only, receiver only, both. Each mode runs two
  // process-count settings; the count plan holds the extremes 0, 1 and 31.
  int idle_plan  [4] = '{0, 53, 0, 34};
  int stall_plan [4] = '{0, 0, 53, 34};
  int count_plan [8] = '{16, 1, 31, 0, 17, 7, 3, 12};

  shortest_remaining_time_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver decides at each falling edge whether to take a result at the
  // next rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_report(out_data);
  end

  // Count cycles in which no channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // Present one input item, with random idle cycles ahead of it, and hold it
  // until its transfer. Valid stays high afterwards so that a following item
  // can go out back to back; the next call replaces or lowers it, and a drain lowers it.
  task automatic send(input srtf_pkg::in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    board.accept_request(req);
    phase_items++;
  endtask

  task automatic send_load(input logic [3:0] slot,
                           input logic [srtf_pkg::TIME_W-1:0] arrival,
                           input logic [srtf_pkg::TIME_W-1:0] burst);
    srtf_pkg::in_item_t req;
    req.operation    = srtf_pkg::OP_LOAD;
    req.slot         = slot;
    req.arrival_time = arrival;
    req.burst_length = burst;
    send(req);
  endtask

  // The other fields of a tick carry random bits; the block must ignore them.
  task automatic send_tick();
    srtf_pkg::in_item_t req;
    req.operation    = srtf_pkg::OP_TICK;
    req.slot         = 4'($urandom);
    req.arrival_time = srtf_pkg::TIME_W'($urandom);
    req.burst_length = srtf_pkg::TIME_W'($urandom);
    send(req);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Only called with the block idle, so the new count applies to a quiet run.
  task automatic write_count(input logic [srtf_pkg::PC_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.job_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed run: load the scanned slots with mostly small jobs, then
  // tick until the run is predicted done, plus a few ticks past the end that
  // must be ignored. Now and then a stray load lands mid-run and restarts it.
  task automatic run_batch();
    int                          jobs;
    int                          budget;
    int                          reach;
    int                          extra;
    logic [srtf_pkg::TIME_W-1:0] arrival;
    logic [srtf_pkg::TIME_W-1:0] burst;
    jobs   = (board.job_count > srtf_pkg::MAX_JOBS) ? srtf_pkg::MAX_JOBS
                                                    : int'(board.job_count);
    budget = 0;
    reach  = 0;
    if (jobs == 0) jobs = $urandom_range(1, 3);
    for (int s = 0; s < jobs; s++) begin
      arrival = ($urandom_range(7) == 0) ? srtf_pkg::TIME_W'($urandom)
                                         : srtf_pkg::TIME_W'($urandom_range(12));
      case ($urandom_range(11))
        0: begin
          burst = '0;
        end
        1: begin
          burst = srtf_pkg::TIME_W'($urandom);
        end
        default: begin
          burst = srtf_pkg::TIME_W'($urandom_range(1, 6));
        end
      endcase
      send_load(4'(s), arrival, burst);
      budget += (burst > 8) ? 40 : int'(burst);
      if (arrival < 64 && int'(arrival) > reach) reach = int'(arrival);
    end
    if ($urandom_range(3) == 0) begin
      send_load(4'($urandom), srtf_pkg::TIME_W'($urandom), srtf_pkg::TIME_W'($urandom));
    end
    budget = (budget + reach + 3 > BATCH_TICKS) ? BATCH_TICKS : budget + reach + 3;
    extra  = $urandom_range(2);
    for (int k = 0; k < budget; k++) begin
      if (board.finished()) begin
        if (extra == 0) break;
        extra--;
      end
      // Occasionally let the pipeline run completely empty before going on.
      if ($urandom_range(63) == 0) drain();
      if ($urandom_range(49) == 0) begin
        send_load(4'($urandom_range(jobs - 1)), srtf_pkg::TIME_W'($urandom_range(8)),
                  srtf_pkg::TIME_W'($urandom_range(1, 5)));
      end
      send_tick();
    end
  endtask

  initial begin
    count_plan[5] = $urandom_range(2, 15);
    count_plan[6] = $urandom_range(2, 15);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset count of 16. Every slot is loaded first so
    // that no scan ever reads a slot that was never written. The set covers
    // a one-tick job, preemption by a shorter arrival, a tie won by the lower
    // slot, unused slots and the field extremes.
    for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
      case (s)
        0: begin
          send_load(4'(s), 16'd2, 16'd2);
        end
        1: begin
          send_load(4'(s), 16'd0, 16'd4);
        end
        3: begin
          send_load(4'(s), 16'd1, 16'd2);
        end
        4: begin
          send_load(4'(s), 16'd3, 16'd2);
        end
        5: begin
          send_load(4'(s), 16'd0, 16'd1);
        end
        14: begin
          send_load(4'(s), 16'd0, 16'hFFFF);
        end
        15: begin
          send_load(4'(s), 16'hFFFF, 16'hFFFF);
        end
        default: begin
          send_load(4'(s), srtf_pkg::TIME_W'(s), 16'd0);
        end
      endcase
    end
    repeat (9) send_tick();

    // Random part: four idling modes, two process counts each.
    for (int p = 0; p < 8; p++) begin
      drain();
      send_idle_pct  = idle_plan[p / 2];
      recv_stall_pct = stall_plan[p / 2];
      write_count(srtf_pkg::PC_W'(count_plan[p]));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) run_batch();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
